// ===== hdl/nice_pkg.sv =====
// shared types and constants for the instruction cycle estimator
`timescale 1ns / 1ps
`default_nettype none
package nice_pkg;

  typedef enum logic [2:0] {
    REQ_DMA_LOAD  = 3'd0,
    REQ_DMA_STORE = 3'd1,
    REQ_MATMUL    = 3'd2,
    REQ_ELTWISE   = 3'd3,
    REQ_ACT       = 3'd4,
    REQ_REDUCE    = 3'd5,
    REQ_SYNC      = 3'd6,
    REQ_OTHER     = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_e;

  // register indexes
  localparam logic [2:0] REG_ELEM  = 3'd0;
  localparam logic [2:0] REG_BURST = 3'd1;
  localparam logic [2:0] REG_DBW   = 3'd2;
  localparam logic [2:0] REG_DOVH  = 3'd3;
  localparam logic [2:0] REG_MACS  = 3'd4;
  localparam logic [2:0] REG_SIMD  = 3'd5;
  localparam logic [2:0] REG_SFU   = 3'd6;
  localparam logic [2:0] REG_ARGM  = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the item and set up operands
    logic row_step;  // one step of a dma row: divide or accumulate
    logic div_start; // launch the divider
    logic div_step;  // one restoring step
    logic post;      // finish: add overheads / multiply
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dma;
    logic rows_done;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/nice_datapath.sv =====
// datapath: row burst counter, serial divider and final cost arithmetic
`timescale 1ns / 1ps
`default_nettype none
module nice_datapath #(
  parameter int unsigned ActOverhead = 8,
  parameter int unsigned TreeSteps   = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire nice_pkg::cmd_t       cmd_i,
  output nice_pkg::sts_t            sts_o,
  input  wire logic [2:0]           req_type_i,
  input  wire logic [31:0]          base_address_i,
  input  wire logic [31:0]          source_stride_i,
  input  wire logic [31:0]          dest_stride_i,
  input  wire logic [15:0]          row_count_i,
  input  wire logic [15:0]          col_count_i,
  input  wire logic [15:0]          dim_m_i,
  input  wire logic [15:0]          dim_n_i,
  input  wire logic [15:0]          dim_k_i,
  input  wire logic [31:0]          act_elements_i,
  input  wire logic                 special_kind_i,
  input  wire logic [3:0]           element_bytes_i,
  input  wire logic [12:0]          burst_bytes_i,
  input  wire logic [10:0]          dma_bytes_per_cycle_i,
  input  wire logic [15:0]          dma_overhead_i,
  input  wire logic [15:0]          macs_per_cycle_i,
  input  wire logic [10:0]          simd_lanes_i,
  input  wire logic [10:0]          sfu_lanes_i,
  input  wire logic [10:0]          argmax_lanes_i,
  output logic [63:0]               cycle_estimate_o,
  output logic                      bad_request_o
);
  import nice_pkg::*;

  localparam int unsigned DivW = 64;

  req_e        req_q;
  logic        special_q;
  logic [15:0] k_q;
  logic [15:0] rows_q, rows_d;
  logic [15:0] row_idx_q, row_idx_d;
  logic [31:0] start_q, start_d;
  logic [31:0] stride_q, stride_d;
  logic [31:0] row_bytes_q, row_bytes_d;
  logic [12:0] blk_q, blk_d;
  logic [63:0] acc_q, acc_d;
  // start/blk and last/blk run through the shared divider one row at a time
  logic [31:0] last_div_q, last_div_d, start_div_q, start_div_d;
  logic [1:0]  row_ph_q, row_ph_d;
  // serial divider
  logic [DivW-1:0] quo_q, quo_d, rem_q, rem_d, dvd_q, dvd_d;
  logic [15:0]     dvs_q, dvs_d;
  logic [6:0]      dcnt_q, dcnt_d;
  logic [63:0]     res_q, res_d;
  logic            bad_q, bad_d;
  req_e            req_d;
  logic            special_d;
  logic [15:0]     k_d;

  logic [63:0] div_num;
  logic [15:0] div_den;
  logic [64:0] rem_sh;
  logic [31:0] last_w;
  logic [31:0] term_w;
  logic        row_div_busy;

  function automatic logic [15:0] nz16(input logic [15:0] v);
    nz16 = (v == 16'd0) ? 16'd1 : v;
  endfunction

  assign last_w = start_q + row_bytes_q - 32'd1;
  assign term_w = last_div_q - start_div_q + 32'd1;
  assign row_div_busy = 1'b0;

  // numerator and divisor for the final ceil division
  always_comb begin
    div_num = 64'd0;
    div_den = 16'd1;
    case (req_q)
      REQ_DMA_LOAD, REQ_DMA_STORE: begin
        div_num = acc_q;
        div_den = nz16({5'd0, dma_bytes_per_cycle_i});
      end
      REQ_MATMUL: begin
        div_num = acc_q;
        div_den = nz16(macs_per_cycle_i);
      end
      REQ_ELTWISE: begin
        div_num = acc_q;
        div_den = nz16({5'd0, simd_lanes_i});
      end
      REQ_ACT: begin
        div_num = acc_q;
        div_den = special_q ? nz16({5'd0, simd_lanes_i}) : nz16({5'd0, sfu_lanes_i});
      end
      REQ_REDUCE: begin
        div_num = acc_q;
        div_den = special_q ? nz16({5'd0, argmax_lanes_i}) : nz16({5'd0, simd_lanes_i});
      end
      default: begin
        div_num = 64'd0;
        div_den = 16'd1;
      end
    endcase
  end

  assign rem_sh = {rem_q, dvd_q[DivW-1]};

  always_comb begin
    req_d       = req_q;
    special_d   = special_q;
    k_d         = k_q;
    rows_d      = rows_q;
    row_idx_d   = row_idx_q;
    start_d     = start_q;
    stride_d    = stride_q;
    row_bytes_d = row_bytes_q;
    blk_d       = blk_q;
    acc_d       = acc_q;
    last_div_d  = last_div_q;
    start_div_d = start_div_q;
    row_ph_d    = row_ph_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    dcnt_d      = dcnt_q;
    res_d       = res_q;
    bad_d       = bad_q;
    if (cmd_i.load) begin
      req_d       = req_e'(req_type_i);
      special_d   = special_kind_i;
      k_d         = dim_k_i;
      rows_d      = row_count_i;
      row_idx_d   = 16'd0;
      start_d     = base_address_i;
      stride_d    = (req_e'(req_type_i) == REQ_DMA_STORE) ? dest_stride_i : source_stride_i;
      row_bytes_d = {16'd0, col_count_i} * {28'd0, element_bytes_i};
      blk_d       = (burst_bytes_i == 13'd0) ? 13'd1 : burst_bytes_i;
      row_ph_d    = 2'd0;
      bad_d       = (req_e'(req_type_i) == REQ_OTHER);
      case (req_e'(req_type_i))
        REQ_MATMUL:              acc_d = {32'd0, {16'd0, dim_m_i} * {16'd0, dim_n_i}};
        REQ_ELTWISE, REQ_REDUCE: acc_d = {32'd0, {16'd0, row_count_i} * {16'd0, col_count_i}};
        REQ_ACT:                 acc_d = {32'd0, act_elements_i};
        default:                 acc_d = 64'd0;
      endcase
    end
    if (cmd_i.row_step) begin
      // row phases: 0 divide start, 1 divide last, 2 accumulate
      case (row_ph_q)
        2'd0: begin
          if (dcnt_q == 7'd0) begin
            dvd_d  = {start_q, 32'd0};
            rem_d  = '0;
            quo_d  = '0;
            dvs_d  = {3'd0, blk_q};
            dcnt_d = 7'd32;
          end else begin
            if (rem_sh >= {49'd0, dvs_q}) begin
              rem_d = rem_sh[63:0] - {48'd0, dvs_q};
              quo_d = {quo_q[62:0], 1'b1};
            end else begin
              rem_d = rem_sh[63:0];
              quo_d = {quo_q[62:0], 1'b0};
            end
            dvd_d  = {dvd_q[62:0], 1'b0};
            dcnt_d = dcnt_q - 7'd1;
            if (dcnt_q == 7'd1) begin
              start_div_d = quo_d[31:0];
              row_ph_d    = 2'd1;
            end
          end
        end
        2'd1: begin
          if (dcnt_q == 7'd0) begin
            dvd_d  = {last_w, 32'd0};
            rem_d  = '0;
            quo_d  = '0;
            dcnt_d = 7'd32;
          end else begin
            if (rem_sh >= {49'd0, dvs_q}) begin
              rem_d = rem_sh[63:0] - {48'd0, dvs_q};
              quo_d = {quo_q[62:0], 1'b1};
            end else begin
              rem_d = rem_sh[63:0];
              quo_d = {quo_q[62:0], 1'b0};
            end
            dvd_d  = {dvd_q[62:0], 1'b0};
            dcnt_d = dcnt_q - 7'd1;
            if (dcnt_q == 7'd1) begin
              last_div_d = quo_d[31:0];
              row_ph_d   = 2'd2;
            end
          end
        end
        default: begin
          acc_d     = acc_q + {32'd0, term_w};
          start_d   = start_q + stride_q;
          row_idx_d = row_idx_q + 16'd1;
          row_ph_d  = 2'd0;
        end
      endcase
    end
    if (cmd_i.div_start) begin
      // dma: bursts*blk; both operands narrow enough for one product
      if (req_q == REQ_DMA_LOAD || req_q == REQ_DMA_STORE) begin
        acc_d = acc_q[47:0] * {35'd0, blk_q};
      end
      dcnt_d = 7'd64;
      rem_d  = '0;
      quo_d  = '0;
    end
    if (cmd_i.div_step) begin
      if (dcnt_q == 7'd64) begin
        dvd_d = div_num;
        dvs_d = div_den;
      end
      begin
        if ({rem_q, (dcnt_q == 7'd64) ? div_num[63] : dvd_q[63]} >= {49'd0,
            (dcnt_q == 7'd64) ? div_den : dvs_q}) begin
          rem_d = {rem_q[62:0], (dcnt_q == 7'd64) ? div_num[63] : dvd_q[63]}
                  - {48'd0, (dcnt_q == 7'd64) ? div_den : dvs_q};
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[62:0], (dcnt_q == 7'd64) ? div_num[63] : dvd_q[63]};
          quo_d = {quo_q[62:0], 1'b0};
        end
        dvd_d  = (dcnt_q == 7'd64) ? {div_num[62:0], 1'b0} : {dvd_q[62:0], 1'b0};
        dcnt_d = dcnt_q - 7'd1;
      end
    end
    if (cmd_i.post) begin
      // ceil correction then the class-specific finish
      res_d = quo_q + ((rem_q != 64'd0) ? 64'd1 : 64'd0);
      case (req_q)
        REQ_DMA_LOAD, REQ_DMA_STORE: res_d = res_d + {48'd0, dma_overhead_i};
        // the matmul quotient never exceeds 32 bits
        REQ_MATMUL:  res_d = {16'd0, {16'd0, res_d[31:0]} * {32'd0, k_q}};
        REQ_ACT:     res_d = special_q ? res_d : res_d + 64'(ActOverhead);
        REQ_REDUCE:  res_d = res_d + {48'd0, rows_q} * 64'(TreeSteps);
        REQ_ELTWISE: res_d = res_d;
        default:     res_d = 64'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q   <= 7'd0;
      row_ph_q <= 2'd0;
    end else begin
      dcnt_q   <= dcnt_d;
      row_ph_q <= row_ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    special_q   <= special_d;
    k_q         <= k_d;
    rows_q      <= rows_d;
    row_idx_q   <= row_idx_d;
    start_q     <= start_d;
    stride_q    <= stride_d;
    row_bytes_q <= row_bytes_d;
    blk_q       <= blk_d;
    acc_q       <= acc_d;
    last_div_q  <= last_div_d;
    start_div_q <= start_div_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    dvs_q       <= dvs_d;
    res_q       <= res_d;
    bad_q       <= bad_d;
  end

  assign sts_o.is_dma    = (req_q == REQ_DMA_LOAD) || (req_q == REQ_DMA_STORE) || row_div_busy;
  assign sts_o.rows_done = (row_idx_q == rows_q);
  assign sts_o.div_done  = (dcnt_q == 7'd0);

  assign cycle_estimate_o = res_q;
  assign bad_request_o    = bad_q;

`ifndef SYNTHESIS
  a_row_step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_step |-> row_idx_q < rows_q)
    else $error("row step past last row");
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= 7'd64)
    else $error("divider count out of range");
  a_load_resets_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> row_idx_q == 16'd0)
    else $error("row index not cleared on load");
`endif

endmodule
`default_nettype wire

// ===== hdl/nice_ctrl.sv =====
// controller: sequences row walk, division and finish for one item
`timescale 1ns / 1ps
`default_nettype none
module nice_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire nice_pkg::sts_t sts_i,
  output nice_pkg::cmd_t      cmd_o
);
  import nice_pkg::*;

  state_e state_q, state_d;
  logic   first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    first_d     = 1'b0;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ROW;
        end
      end
      ST_ROW: begin
        if (!sts_i.is_dma || sts_i.rows_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
          first_d         = 1'b1;
        end else begin
          cmd_o.row_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done && !first_q) begin
          state_d = ST_POST;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_POST: begin
        cmd_o.post = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_ROW;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == ST_OUT)
    else $error("result shown outside output state");
  a_post_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.post |=> out_valid_o)
    else $error("finish not followed by result");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.row_step, cmd_o.div_start, cmd_o.div_step, cmd_o.post}))
    else $error("conflicting datapath commands");
`endif

endmodule
`default_nettype wire

// ===== hdl/nice_regs.sv =====
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none
module nice_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [3:0]       element_bytes_o,
  output logic [12:0]      burst_bytes_o,
  output logic [10:0]      dma_bytes_per_cycle_o,
  output logic [15:0]      dma_overhead_o,
  output logic [15:0]      macs_per_cycle_o,
  output logic [10:0]      simd_lanes_o,
  output logic [10:0]      sfu_lanes_o,
  output logic [10:0]      argmax_lanes_o
);
  import nice_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_bytes_o       <= 4'd2;
      burst_bytes_o         <= 13'd64;
      dma_bytes_per_cycle_o <= 11'd32;
      dma_overhead_o        <= 16'd32;
      macs_per_cycle_o      <= 16'd256;
      simd_lanes_o          <= 11'd16;
      sfu_lanes_o           <= 11'd4;
      argmax_lanes_o        <= 11'd8;
    end else if (wr) begin
      case (idx)
        REG_ELEM:  element_bytes_o       <= pwdata[3:0];
        REG_BURST: burst_bytes_o         <= pwdata[12:0];
        REG_DBW:   dma_bytes_per_cycle_o <= pwdata[10:0];
        REG_DOVH:  dma_overhead_o        <= pwdata[15:0];
        REG_MACS:  macs_per_cycle_o      <= pwdata[15:0];
        REG_SIMD:  simd_lanes_o          <= pwdata[10:0];
        REG_SFU:   sfu_lanes_o           <= pwdata[10:0];
        REG_ARGM:  argmax_lanes_o        <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ELEM:  prdata = {28'd0, element_bytes_o};
      REG_BURST: prdata = {19'd0, burst_bytes_o};
      REG_DBW:   prdata = {21'd0, dma_bytes_per_cycle_o};
      REG_DOVH:  prdata = {16'd0, dma_overhead_o};
      REG_MACS:  prdata = {16'd0, macs_per_cycle_o};
      REG_SIMD:  prdata = {21'd0, simd_lanes_o};
      REG_SFU:   prdata = {21'd0, sfu_lanes_o};
      REG_ARGM:  prdata = {21'd0, argmax_lanes_o};
      default:   prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/npu_instruction_cycle_estimator_top.sv =====
// top level: apb registers, controller and datapath
// sequence: dma items first walk each row (two 32-step divisions per row for the start
// and end burst), then every class runs a 64-step division before the result is valid
// throughput: one item at a time, set by the serial divider
// the result register holds until taken; a new item may be taken in the same cycle
// reset: asynchronous active low; configuration registers return to their defaults
`timescale 1ns / 1ps
`default_nettype none
module npu_instruction_cycle_estimator_top #(
  parameter int unsigned ACT_OVERHEAD = 8,
  parameter int unsigned TREE_STEPS   = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [31:0] base_address_i,
  input  wire logic [31:0] source_stride_i,
  input  wire logic [31:0] dest_stride_i,
  input  wire logic [15:0] row_count_i,
  input  wire logic [15:0] col_count_i,
  input  wire logic [15:0] dim_m_i,
  input  wire logic [15:0] dim_n_i,
  input  wire logic [15:0] dim_k_i,
  input  wire logic [31:0] act_elements_i,
  input  wire logic        special_kind_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      cycle_estimate_o,
  output logic             bad_request_o
);
  import nice_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [3:0]  eb;
  logic [12:0] bb;
  logic [10:0] dbw, simd, sfu, argm;
  logic [15:0] dovh, macs;

  nice_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .element_bytes_o(eb), .burst_bytes_o(bb), .dma_bytes_per_cycle_o(dbw),
    .dma_overhead_o(dovh), .macs_per_cycle_o(macs), .simd_lanes_o(simd),
    .sfu_lanes_o(sfu), .argmax_lanes_o(argm)
  );

  nice_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  nice_datapath #(.ActOverhead(ACT_OVERHEAD), .TreeSteps(TREE_STEPS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i, .base_address_i, .source_stride_i, .dest_stride_i,
    .row_count_i, .col_count_i, .dim_m_i, .dim_n_i, .dim_k_i,
    .act_elements_i, .special_kind_i,
    .element_bytes_i(eb), .burst_bytes_i(bb), .dma_bytes_per_cycle_i(dbw),
    .dma_overhead_i(dovh), .macs_per_cycle_i(macs), .simd_lanes_i(simd),
    .sfu_lanes_i(sfu), .argmax_lanes_i(argm),
    .cycle_estimate_o, .bad_request_o
  );

`ifndef SYNTHESIS
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");
  a_stable_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cycle_estimate_o))
    else $error("result changed while stalled");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
`endif

endmodule
`default_nettype wire
